FILE: rtl/rrts_pkg.sv
// Package for the round-robin task scheduler: task status codes, opcodes,
// controller states and the command/status structs. No dependencies.
package rrts_pkg;

  localparam int unsigned MaxTasksDefault = 16;
  localparam logic [29:0] TimebaseReset = 30'd10000000;
  // ceil(2^70 / 15625): x / 15625 == (x * UsecRecip) >> 70 for any x below 2^56
  localparam logic [56:0] UsecRecip = 57'd75557863725914324;

  typedef enum logic [2:0] {
    TS_RUNNABLE = 3'd0,
    TS_RUNNING  = 3'd1,
    TS_WAITING  = 3'd2,
    TS_SLEEPING = 3'd3,
    TS_ZOMBIE   = 3'd4
  } task_st_e;

  typedef enum logic [3:0] {
    OP_CREATE_K = 4'd0,
    OP_CREATE_U = 4'd1,
    OP_SCHED    = 4'd2,
    OP_EXIT     = 4'd3,
    OP_STOP     = 4'd4,
    OP_WAITPID  = 4'd5,
    OP_SLEEP    = 4'd6,
    OP_TICK     = 4'd7,
    OP_REAP     = 4'd8
  } op_e;

  typedef enum logic [1:0] {
    RS_OK      = 2'd0,
    RS_ERROR   = 2'd1,
    RS_BLOCKED = 2'd2
  } rstat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ZOMB,
    S_WAKE,
    S_WAITCHK,
    S_MUL,
    S_DIV,
    S_SLEEPSET,
    S_SCHED,
    S_DONE
  } ctl_state_e;

  // scan kinds run by the datapath walker
  typedef enum logic [2:0] {
    SK_FREE,
    SK_ORPHAN,
    SK_REAPCHILD,
    SK_TICK,
    SK_REAP,
    SK_SCHED
  } scan_e;

  typedef struct packed {
    logic   load;      // latch request, clear result
    logic   scan_go;   // start a scan
    scan_e  scan_kind;
    logic   create;    // write the found free slot
    logic   zombie;    // make zombie_tgt a zombie
    logic   wake_par;  // wake parent of zombie_tgt if it matches
    logic   set_wait;  // current becomes waiting
    logic   mul_go;
    logic   div_go;
    logic   set_sleep;
    logic   sched_go;  // commit scheduler pick
    logic   err;
    logic   blocked;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic   scan_busy;
    logic   found;
    logic   cur_valid;
    logic   stop_ok;
    logic   waitchk_ok;
    logic   div_busy;
  } sts_t;

endpackage

FILE: rtl/round_robin_task_scheduler.sv
// Round-robin task scheduler, top level: stream ports, output register and
// checks. Depends on rrts_pkg, rrts_ctrl and rrts_datapath.
//
// One request at a time is processed. After decode, a full walk of the task
// table visits every slot (a scheduling walk skips the current slot) and a
// walk that stops at its first hit ends sooner. Create, tick and reap walk
// once. Exit walks once to orphan children, wakes a waiting parent and walks
// again to pick the next task; a waitpid that blocks walks once for a zombie
// child, checks its target and walks again to pick the next task. Sleep does
// a multiply and a four-step reciprocal multiply by 1/1000000 before its
// scheduling walk. The result sits in an output register; a new result waits
// while the sink holds m_tready_i low on an older result. The timebase
// register may be written whenever the block is idle.
module round_robin_task_scheduler #(
  parameter int unsigned MaxTasks = rrts_pkg::MaxTasksDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [29:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // opcode[3:0], target_pid[7:4], wait_any[8], sleep_usec[40:9], now[104:41]
  input  logic [111:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // status[1:0], result_pid[5:2], running_pid[9:6], switched[10], freed_count[15:11]
  output logic [15:0]  m_tdata_o
);
  import rrts_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ready, ovalid_q;
  logic [1:0] status;
  logic [3:0] rpid, runpid;
  logic sw;
  logic [4:0] freed;

  rrts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_i      (s_tvalid_i),
    .opcode_i   (s_tdata_i[3:0]),
    .out_free_i (!ovalid_q || m_tready_i),
    .sts_i      (sts),
    .ready_o    (ready),
    .cmd_o      (cmd)
  );

  rrts_datapath #(.MaxTasks(MaxTasks)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i         (cmd),
    .cfg_we_i, .cfg_data_i,
    .opcode_i      (s_tdata_i[3:0]),
    .target_pid_i  (s_tdata_i[7:4]),
    .wait_any_i    (s_tdata_i[8]),
    .sleep_usec_i  (s_tdata_i[40:9]),
    .now_i         (s_tdata_i[104:41]),
    .sts_o         (sts),
    .status_o      (status),
    .result_pid_o  (rpid),
    .running_pid_o (runpid),
    .switched_o    (sw),
    .freed_count_o (freed)
  );

  assign s_tready_o = ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (cmd.out_load) ovalid_q <= 1'b1;
    else if (m_tready_i) ovalid_q <= 1'b0;
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o  = {freed, sw, runpid, rpid, status};

  // a result is only loaded when the output slot is free
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!ovalid_q || m_tready_i)) else $error("result overwritten");
  // no request accepted while a walk is running
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.scan_busy |-> !s_tready_o) else $error("ready during scan");
  // a reported result never exceeds the status range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[1:0] != 2'd3)) else $error("bad status");

endmodule

FILE: rtl/rrts_ctrl.sv
// Controller FSM of the task scheduler. Sequences datapath scans and units.
// Depends on rrts_pkg.
module rrts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_i,
  input  logic [3:0]      opcode_i,
  input  logic            out_free_i,
  input  rrts_pkg::sts_t  sts_i,
  output logic            ready_o,
  output rrts_pkg::cmd_t  cmd_o
);
  import rrts_pkg::*;

  ctl_state_e state_q, state_d;
  logic [3:0] op_q, op_d;
  logic       stop_q, stop_d;  // zombie path came from stop: no reschedule

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= 4'd0;
      stop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      stop_q  <= stop_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    stop_d  = stop_q;
    cmd_o   = '0;
    cmd_o.scan_kind = SK_FREE;
    ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_i) begin
          cmd_o.load = 1'b1;
          op_d    = opcode_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        stop_d  = 1'b0;
        case (op_q)
          OP_CREATE_K, OP_CREATE_U: begin
            cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_FREE; state_d = S_SCAN;
          end
          OP_SCHED: begin
            if (sts_i.cur_valid) begin
              cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_SCHED; state_d = S_SCHED;
            end
          end
          OP_EXIT: begin
            if (!sts_i.cur_valid) cmd_o.err = 1'b1;
            else begin
              cmd_o.zombie = 1'b1; cmd_o.scan_go = 1'b1;
              cmd_o.scan_kind = SK_ORPHAN; state_d = S_ZOMB;
            end
          end
          OP_STOP: begin
            if (!sts_i.stop_ok) cmd_o.err = 1'b1;
            else begin
              cmd_o.zombie = 1'b1; cmd_o.scan_go = 1'b1;
              cmd_o.scan_kind = SK_ORPHAN; stop_d = 1'b1; state_d = S_ZOMB;
            end
          end
          OP_WAITPID: begin
            if (!sts_i.cur_valid) cmd_o.err = 1'b1;
            else begin
              cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_REAPCHILD; state_d = S_SCAN;
            end
          end
          OP_SLEEP: begin
            if (!sts_i.cur_valid) cmd_o.err = 1'b1;
            else begin
              cmd_o.mul_go = 1'b1; state_d = S_MUL;
            end
          end
          OP_TICK: begin
            cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_TICK; state_d = S_SCAN;
          end
          OP_REAP: begin
            cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_REAP; state_d = S_SCAN;
          end
          default: cmd_o.err = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (!sts_i.scan_busy) begin
          state_d = S_DONE;
          case (op_q)
            OP_CREATE_K, OP_CREATE_U: begin
              if (sts_i.found) cmd_o.create = 1'b1;
              else cmd_o.err = 1'b1;
            end
            OP_WAITPID: begin
              if (!sts_i.found) state_d = S_WAITCHK;
            end
            default: ;
          endcase
        end
      end
      S_WAITCHK: begin
        if (!sts_i.waitchk_ok) begin
          cmd_o.err = 1'b1; state_d = S_DONE;
        end else begin
          cmd_o.set_wait = 1'b1; cmd_o.blocked = 1'b1;
          cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_SCHED; state_d = S_SCHED;
        end
      end
      S_ZOMB: begin
        if (!sts_i.scan_busy) begin
          cmd_o.wake_par = 1'b1;
          if (stop_q) state_d = S_DONE;
          else begin
            state_d = S_WAKE;
          end
        end
      end
      S_WAKE: begin
        // parent wake is committed; now pick the next task
        cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_SCHED; state_d = S_SCHED;
      end
      S_MUL: begin
        cmd_o.div_go = 1'b1; state_d = S_DIV;
      end
      S_DIV: begin
        if (!sts_i.div_busy) state_d = S_SLEEPSET;
      end
      S_SLEEPSET: begin
        cmd_o.set_sleep = 1'b1; cmd_o.blocked = 1'b1;
        cmd_o.scan_go = 1'b1; cmd_o.scan_kind = SK_SCHED; state_d = S_SCHED;
      end
      S_SCHED: begin
        if (!sts_i.scan_busy) begin
          cmd_o.sched_go = 1'b1; state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          cmd_o.out_load = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/rrts_datapath.sv
// Datapath of the task scheduler: task table, slot walker, sleep divider
// and result fields. Depends on rrts_pkg.
module rrts_datapath #(
  parameter int unsigned MaxTasks = rrts_pkg::MaxTasksDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rrts_pkg::cmd_t  cmd_i,
  input  logic            cfg_we_i,
  input  logic [29:0]     cfg_data_i,
  input  logic [3:0]      opcode_i,
  input  logic [3:0]      target_pid_i,
  input  logic            wait_any_i,
  input  logic [31:0]     sleep_usec_i,
  input  logic [63:0]     now_i,
  output rrts_pkg::sts_t  sts_o,
  output logic [1:0]      status_o,
  output logic [3:0]      result_pid_o,
  output logic [3:0]      running_pid_o,
  output logic            switched_o,
  output logic [4:0]      freed_count_o
);
  import rrts_pkg::*;

  localparam int unsigned IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW = $clog2(MaxTasks + 1);

  logic [29:0] tb_q;

  // task table
  logic             use_q   [MaxTasks];
  task_st_e         st_q    [MaxTasks];
  logic             user_q  [MaxTasks];
  logic             hpar_q  [MaxTasks];
  logic [IdxW-1:0]  par_q   [MaxTasks];
  logic             wany_q  [MaxTasks];
  logic [3:0]       wpid_q  [MaxTasks];
  logic [63:0]      wake_q  [MaxTasks];
  logic [IdxW-1:0]  cur_q;
  logic             curv_q;

  // latched request
  logic [3:0]  op_q, tgt_q;
  logic        any_q;
  logic [31:0] usec_q;
  logic [63:0] now_q;
  logic [IdxW-1:0] ztgt_q;   // task being made a zombie

  // walker
  logic            busy_q, found_q;
  scan_e           kind_q;
  logic [IdxW-1:0] idx_q, hit_q;
  logic [CntW-1:0] cnt_q;     // steps left
  logic [4:0]      freed_q;

  // sleep arithmetic
  logic [61:0]  prod_q;      // tb * usec
  logic [112:0] acc_q;       // (prod / 64) * UsecRecip
  logic [1:0]   dcnt_q;
  logic         dbusy_q;
  logic [27:0]  pa;
  logic [28:0]  pb;
  logic [56:0]  pp;
  logic [112:0] pp_add;
  logic [42:0]  quo;

  // result
  logic [1:0] rs_q;
  logic [3:0] rpid_q;
  logic       sw_q;
  logic [1:0] status_q;
  logic [3:0] result_pid_q, running_pid_q;
  logic       switched_q;
  logic [4:0] freed_count_q;

  logic tgt_in;
  logic [IdxW-1:0] tgt_idx;
  assign tgt_in  = ({28'd0, tgt_q} < 32'(MaxTasks));
  assign tgt_idx = IdxW'(tgt_q);

  logic [IdxW-1:0] ztgt_sel;
  assign ztgt_sel = (op_q == OP_STOP) ? tgt_idx : cur_q;

  // next walker index with wraparound
  logic [IdxW-1:0] idx_nx;
  assign idx_nx = (32'(idx_q) == MaxTasks - 1) ? '0 : idx_q + 1'b1;

  // per-slot hit for the current scan
  logic hit;
  always_comb begin
    hit = 1'b0;
    unique case (kind_q)
      SK_FREE:      hit = !use_q[idx_q];
      SK_ORPHAN:    hit = use_q[idx_q] && hpar_q[idx_q] && par_q[idx_q] == ztgt_q;
      SK_REAPCHILD: hit = use_q[idx_q] && hpar_q[idx_q] && par_q[idx_q] == cur_q &&
                          st_q[idx_q] == TS_ZOMBIE &&
                          (any_q || {{(32-IdxW){1'b0}}, idx_q} == {28'd0, tgt_q});
      SK_TICK:      hit = use_q[idx_q] && st_q[idx_q] == TS_SLEEPING &&
                          wake_q[idx_q] <= now_q;
      SK_REAP:      hit = use_q[idx_q] && st_q[idx_q] == TS_ZOMBIE &&
                          !(curv_q && idx_q == cur_q) && !(user_q[idx_q] && hpar_q[idx_q]);
      SK_SCHED:     hit = use_q[idx_q] &&
                          (st_q[idx_q] == TS_RUNNABLE || st_q[idx_q] == TS_RUNNING);
      default:      hit = 1'b0;
    endcase
  end
  // scans that stop at the first hit
  logic first_kind;
  assign first_kind = (kind_q == SK_FREE) || (kind_q == SK_REAPCHILD) ||
                      (kind_q == SK_SCHED);

  logic [IdxW-1:0] par_z;
  assign par_z = par_q[ztgt_q];

  // ticks = tb * usec / 1e6: drop the factor 64, then multiply by the
  // reciprocal of 15625 as four 28x29 partial products, one per cycle
  always_comb begin
    unique case (dcnt_q)
      2'd0: begin pa = prod_q[33:6];  pb = {1'b0, UsecRecip[27:0]}; end
      2'd1: begin pa = prod_q[33:6];  pb = UsecRecip[56:28]; end
      2'd2: begin pa = prod_q[61:34]; pb = {1'b0, UsecRecip[27:0]}; end
      default: begin pa = prod_q[61:34]; pb = UsecRecip[56:28]; end
    endcase
    pp = {29'd0, pa} * {28'd0, pb};
    unique case (dcnt_q)
      2'd0:    pp_add = {56'd0, pp};
      2'd3:    pp_add = {pp, 56'd0};
      default: pp_add = {28'd0, pp, 28'd0};
    endcase
  end
  assign quo = acc_q[112:70];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tb_q    <= TimebaseReset;
      cur_q   <= '0;
      curv_q  <= 1'b0;
      busy_q  <= 1'b0;
      dbusy_q <= 1'b0;
      dcnt_q  <= 2'd0;
      for (int i = 0; i < MaxTasks; i++) begin
        use_q[i]  <= 1'b0;
        hpar_q[i] <= 1'b0;
      end
    end else begin
      if (cfg_we_i) tb_q <= cfg_data_i;

      if (cmd_i.load) begin
        op_q   <= opcode_i;
        tgt_q  <= target_pid_i;
        any_q  <= wait_any_i;
        usec_q <= sleep_usec_i;
        now_q  <= now_i;
        rs_q   <= RS_OK;
        rpid_q <= 4'd0;
        sw_q   <= 1'b0;
        freed_q <= 5'd0;
      end

      if (cmd_i.scan_go) begin
        busy_q  <= 1'b1;
        found_q <= 1'b0;
        kind_q  <= cmd_i.scan_kind;
        if (cmd_i.scan_kind == SK_SCHED) begin
          idx_q <= (32'(cur_q) == MaxTasks - 1) ? '0 : cur_q + 1'b1;
          cnt_q <= CntW'(MaxTasks - 1);
        end else begin
          idx_q <= '0;
          cnt_q <= CntW'(MaxTasks);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) busy_q <= 1'b0;
        else begin
          if (hit) begin
            unique case (kind_q)
              SK_ORPHAN: hpar_q[idx_q] <= 1'b0;
              SK_REAPCHILD: begin
                use_q[idx_q]  <= 1'b0;
                hpar_q[idx_q] <= 1'b0;
                rpid_q        <= 4'(idx_q);
              end
              SK_TICK: begin
                st_q[idx_q]   <= TS_RUNNABLE;
                wake_q[idx_q] <= 64'd0;
              end
              SK_REAP: begin
                use_q[idx_q]  <= 1'b0;
                hpar_q[idx_q] <= 1'b0;
                freed_q       <= freed_q + 5'd1;
              end
              default: ;
            endcase
          end
          if (hit && first_kind) begin
            busy_q  <= 1'b0;
            found_q <= 1'b1;
            hit_q   <= idx_q;
          end else begin
            cnt_q <= cnt_q - 1'b1;
            idx_q <= idx_nx;
          end
        end
      end

      if (cmd_i.create) begin
        use_q[hit_q]  <= 1'b1;
        st_q[hit_q]   <= curv_q ? TS_RUNNABLE : TS_RUNNING;
        user_q[hit_q] <= (op_q == OP_CREATE_U);
        hpar_q[hit_q] <= (op_q == OP_CREATE_U) && curv_q;
        par_q[hit_q]  <= ((op_q == OP_CREATE_U) && curv_q) ? cur_q : '0;
        wany_q[hit_q] <= 1'b0;
        wpid_q[hit_q] <= 4'd0;
        wake_q[hit_q] <= 64'd0;
        rpid_q        <= 4'(hit_q);
        if (!curv_q) begin
          cur_q  <= hit_q;
          curv_q <= 1'b1;
          sw_q   <= 1'b1;
        end
      end

      if (cmd_i.zombie) begin
        st_q[ztgt_sel] <= TS_ZOMBIE;
        ztgt_q         <= ztgt_sel;
      end

      if (cmd_i.wake_par && hpar_q[ztgt_q] && use_q[par_z] &&
          st_q[par_z] == TS_WAITING &&
          (wany_q[par_z] || wpid_q[par_z] == 4'(ztgt_q)))
        st_q[par_z] <= TS_RUNNABLE;

      if (cmd_i.set_wait) begin
        wany_q[cur_q] <= any_q;
        wpid_q[cur_q] <= tgt_q;
        st_q[cur_q]   <= TS_WAITING;
      end

      if (cmd_i.mul_go) prod_q <= 62'(tb_q) * 62'(usec_q);
      if (cmd_i.div_go) begin
        dbusy_q <= 1'b1;
        dcnt_q  <= 2'd0;
        acc_q   <= '0;
      end else if (dbusy_q) begin
        acc_q  <= acc_q + pp_add;
        dcnt_q <= dcnt_q + 2'd1;
        if (dcnt_q == 2'd3) dbusy_q <= 1'b0;
      end

      if (cmd_i.set_sleep) begin
        wake_q[cur_q] <= now_q + ((quo == '0) ? 64'd1 : 64'(quo));
        st_q[cur_q]   <= TS_SLEEPING;
      end

      if (cmd_i.sched_go && found_q) begin
        if (st_q[cur_q] == TS_RUNNING && hit_q != cur_q) st_q[cur_q] <= TS_RUNNABLE;
        st_q[hit_q] <= TS_RUNNING;
        cur_q <= hit_q;
        sw_q  <= 1'b1;
      end

      if (cmd_i.err) rs_q <= RS_ERROR;
      if (cmd_i.blocked) rs_q <= RS_BLOCKED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q      <= rs_q;
      result_pid_q  <= rpid_q;
      running_pid_q <= curv_q ? 4'(cur_q) : 4'd0;
      switched_q    <= sw_q;
      freed_count_q <= freed_q;
    end
  end

  assign sts_o.scan_busy  = busy_q;
  assign sts_o.found      = found_q;
  assign sts_o.cur_valid  = curv_q;
  assign sts_o.stop_ok    = tgt_in && use_q[tgt_idx] && !(curv_q && tgt_idx == cur_q) &&
                            st_q[tgt_idx] != TS_ZOMBIE;
  assign sts_o.waitchk_ok = any_q || (tgt_in && use_q[tgt_idx] && hpar_q[tgt_idx] &&
                            par_q[tgt_idx] == cur_q);
  assign sts_o.div_busy   = dbusy_q;

  assign status_o      = status_q;
  assign result_pid_o  = result_pid_q;
  assign running_pid_o = running_pid_q;
  assign switched_o    = switched_q;
  assign freed_count_o = freed_count_q;

endmodule
